>>> hw/rtl/tcf_pkg.sv
// Shared types, constants and the CORDIC angle table for the tilt filter.
`default_nettype none
package tcf_pkg;

  // CORDIC datapath widths: vector components and angle accumulator
  localparam int CW = 36;
  localparam int ZW = 27;

  localparam logic signed [ZW-1:0] DEG180 = 27'sd11796480;

  // integration step: round(g*dt*65536 / 131000000)
  localparam int StepW = 52;
  localparam int StepRw = 27;
  localparam logic [StepRw-1:0] STEP_DIV = 27'd131000000;
  localparam logic [StepW-1:0] STEP_HALF = 52'd65500000;

  // rate scaling: round(g*256 / 131)
  localparam int RateW = 24;
  localparam int RateRw = 8;
  localparam logic [RateRw-1:0] RATE_DIV = 8'd131;
  localparam logic [RateW-1:0] RATE_HALF = 24'd65;

  localparam logic [15:0] ALPHA_RST = 16'd64225;

  // configuration register indexes
  localparam logic CFG_SENSOR_OK = 1'b0;
  localparam logic CFG_ALPHA = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_LOAD,
    ST_RUN,
    ST_DIFF,
    ST_BLEND,
    ST_ROUND,
    ST_FIN
  } tcf_state_e;

  // round(atan(2^-i) degrees * 65536)
  function automatic logic signed [ZW-1:0] atan_step(input logic [4:0] idx);
    logic signed [ZW-1:0] r;
    begin
      case (idx)
        5'd0: r = 27'sd2949120;
        5'd1: r = 27'sd1740967;
        5'd2: r = 27'sd919879;
        5'd3: r = 27'sd466945;
        5'd4: r = 27'sd234379;
        5'd5: r = 27'sd117304;
        5'd6: r = 27'sd58666;
        5'd7: r = 27'sd29335;
        5'd8: r = 27'sd14668;
        5'd9: r = 27'sd7334;
        5'd10: r = 27'sd3667;
        5'd11: r = 27'sd1833;
        5'd12: r = 27'sd917;
        5'd13: r = 27'sd458;
        5'd14: r = 27'sd229;
        5'd15: r = 27'sd115;
        5'd16: r = 27'sd57;
        5'd17: r = 27'sd29;
        5'd18: r = 27'sd14;
        5'd19: r = 27'sd7;
        5'd20: r = 27'sd4;
        5'd21: r = 27'sd2;
        5'd22: r = 27'sd1;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/tcf_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
`default_nettype none
module tcf_div #(
  parameter int DW = 52,
  parameter int RW = 27
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [RW-1:0] divisor_i,
  output logic      [DW-1:0] quot_o,
  output logic               done_o
);

  localparam int CNTW = $clog2(DW);

  logic            busy_q, busy_d, done_q, done_d;
  logic [CNTW-1:0] cnt_q;
  logic [RW-1:0]   rem_q;
  logic [DW-1:0]   quo_q;
  logic [RW:0]     trial, diff;
  logic            ge;

  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign ge    = trial >= {1'b0, divisor_i};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
    end else if (busy_q && cnt_q == CNTW'(DW - 1)) begin
      busy_d = 1'b0;
      done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      cnt_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[RW-1:0] : trial[RW-1:0];
      quo_q <= {quo_q[DW-2:0], ge};
      cnt_q <= cnt_q + 1'b1;
    end
  end

  assign quot_o = quo_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

>>> hw/rtl/tcf_cordic.sv
// Vectoring CORDIC, one rotation per cycle, atan2 in 1/65536 degree.
`default_nettype none
module tcf_cordic import tcf_pkg::*; #(
  parameter int STEPS = 16
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic signed [CW-1:0] x_i,
  input  wire logic signed [CW-1:0] y_i,
  output logic signed      [ZW-1:0] angle_o,
  output logic                      done_o
);

  localparam int IW = $clog2(STEPS);

  logic                 busy_q, done_q, last;
  logic [IW-1:0]        cnt_q;
  logic signed [CW-1:0] x_q, y_q, xs, ys;
  logic signed [ZW-1:0] z_q, tab;
  logic                 zero_q;

  assign last = cnt_q == IW'(STEPS - 1);
  assign xs   = x_q >>> cnt_q;
  assign ys   = y_q >>> cnt_q;
  assign tab  = atan_step(5'(cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (last) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cnt_q  <= '0;
      zero_q <= (x_i == '0) && (y_i == '0);
      // left half plane: flip the vector, start from +/-180
      if (x_i < 0) begin
        x_q <= -x_i;
        y_q <= -y_i;
        z_q <= (y_i >= 0) ? DEG180 : -DEG180;
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (!y_q[CW-1]) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + tab;
      end else begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - tab;
      end
    end
  end

  assign angle_o = zero_q ? '0 : z_q;
  assign done_o  = done_q;

endmodule
`default_nettype wire

>>> hw/rtl/tilt_complementary_filter.sv
// Top level: accel/gyro complementary tilt filter with serial arithmetic units.
// An accepted item passes prep, load, the serial units, diff, blend, round and finish; the
//   long pole is the step-time dividers below 26 steps, else the isqrt + second CORDIC
//   pass. A rejected item (sensor_ok clear or zero dt) goes straight to finish.
// One item in flight: a new item is taken only once the last has left the finish state;
//   the next item is taken while a finished result waits. Reset: angles, rates and accel
//   record clear to zero, sensor_ok = 0, alpha = 64225.
`default_nettype none
module tilt_complementary_filter import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic               cfg_idx_i,
  input  wire logic        [15:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] accel_x_i,
  input  wire logic signed [15:0] accel_y_i,
  input  wire logic signed [15:0] accel_z_i,
  input  wire logic signed [15:0] gyro_x_i,
  input  wire logic signed [15:0] gyro_y_i,
  input  wire logic        [19:0] step_time_us_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed      [31:0] tilt_x_o,
  output logic signed      [31:0] tilt_y_o,
  output logic signed      [16:0] rate_x_o,
  output logic signed      [16:0] rate_y_o,
  output logic signed      [15:0] accel_x_g_o,
  output logic signed      [15:0] accel_y_g_o,
  output logic signed      [15:0] accel_z_g_o,
  output logic                    sample_valid_o
);

  tcf_state_e state_q, state_d;

  // config registers
  logic        sensor_ok_q;
  logic [15:0] alpha_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_ok_q <= 1'b0;
      alpha_q     <= ALPHA_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SENSOR_OK: sensor_ok_q <= cfg_wdata_i[0];
        CFG_ALPHA:     alpha_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // handshake / sequencing controls
  logic accept, in_ok, load_go, cy_start, fin_go, all_done;

  assign accept = in_valid_i && in_ready_o;
  assign in_ok  = sensor_ok_q && (step_time_us_i != '0);

  // latched item
  logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
  logic        [19:0] dt_q;
  logic               ok_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ax_q <= accel_x_i;
      ay_q <= accel_y_i;
      az_q <= accel_z_i;
      gx_q <= gyro_x_i;
      gy_q <= gyro_y_i;
      dt_q <= step_time_us_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ok_q <= 1'b0;
    end else if (accept) begin
      ok_q <= in_ok;
    end
  end

  // gyro magnitudes; -(-32768) lands on 16'h8000 which reads right unsigned
  logic [15:0] gxm, gym;
  assign gxm = gx_q[15] ? 16'(-gx_q) : 16'(gx_q);
  assign gym = gy_q[15] ? 16'(-gy_q) : 16'(gy_q);

  // prep products
  logic        [35:0] gdx_q, gdy_q;
  logic signed [31:0] sqy_q, sqz_q;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_PREP) begin
      gdx_q <= gxm * dt_q;
      gdy_q <= gym * dt_q;
      sqy_q <= ay_q * ay_q;
      sqz_q <= az_q * az_q;
    end
  end

  // dividers: two integration steps, two rate scalings
  logic [StepW-1:0] qsx, qsy;
  logic [RateW-1:0] qrx, qry;
  logic [3:0]       dv_done;
  logic [3:0]       dvd_q;

  tcf_div #(.DW(StepW), .RW(StepRw)) u_div_sx (
    .clk_i, .rst_ni, .start_i(load_go),
    .dividend_i({gdx_q, 16'd0} + STEP_HALF), .divisor_i(STEP_DIV),
    .quot_o(qsx), .done_o(dv_done[0])
  );

  tcf_div #(.DW(StepW), .RW(StepRw)) u_div_sy (
    .clk_i, .rst_ni, .start_i(load_go),
    .dividend_i({gdy_q, 16'd0} + STEP_HALF), .divisor_i(STEP_DIV),
    .quot_o(qsy), .done_o(dv_done[1])
  );

  tcf_div #(.DW(RateW), .RW(RateRw)) u_div_rx (
    .clk_i, .rst_ni, .start_i(load_go),
    .dividend_i({gxm, 8'd0} + RATE_HALF), .divisor_i(RATE_DIV),
    .quot_o(qrx), .done_o(dv_done[2])
  );

  tcf_div #(.DW(RateW), .RW(RateRw)) u_div_ry (
    .clk_i, .rst_ni, .start_i(load_go),
    .dividend_i({gym, 8'd0} + RATE_HALF), .divisor_i(RATE_DIV),
    .quot_o(qry), .done_o(dv_done[3])
  );

  // integer square root of (ay^2 + az^2) << 16, two radicand bits per cycle
  logic [47:0] sq_n_q;
  logic [25:0] sq_rem_q;
  logic [23:0] sq_root_q;
  logic [4:0]  sq_cnt_q;
  logic        sq_busy_q, sq_last;
  logic [27:0] sq_trial, sq_t;
  logic        sq_ge;

  assign sq_trial = {sq_rem_q, sq_n_q[47:46]};
  assign sq_t     = {2'b00, sq_root_q, 2'b01};
  assign sq_ge    = sq_trial >= sq_t;
  assign sq_last  = sq_busy_q && (sq_cnt_q == 5'd23);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_busy_q <= 1'b0;
    end else if (load_go) begin
      sq_busy_q <= 1'b1;
    end else if (sq_last) begin
      sq_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_go) begin
      sq_n_q    <= {32'($unsigned(sqy_q) + $unsigned(sqz_q)), 16'd0};
      sq_rem_q  <= '0;
      sq_root_q <= '0;
      sq_cnt_q  <= '0;
    end else if (sq_busy_q) begin
      sq_n_q    <= {sq_n_q[45:0], 2'b00};
      sq_rem_q  <= sq_ge ? 26'(sq_trial - sq_t) : sq_trial[25:0];
      sq_root_q <= {sq_root_q[22:0], sq_ge};
      sq_cnt_q  <= sq_cnt_q + 1'b1;
    end
  end

  // shared CORDIC: x-axis angle first, then y-axis angle once the magnitude is in
  logic signed [CW-1:0] cx_in, cy_in;
  logic signed [ZW-1:0] cord_angle;
  logic                 cord_done;

  always_comb begin
    if (cy_start) begin
      cx_in = $signed({4'd0, sq_root_q, 8'd0});
      cy_in = CW'(0) - $signed({{4{ax_q[15]}}, ax_q, 16'd0});
    end else begin
      cx_in = $signed({{4{az_q[15]}}, az_q, 16'd0});
      cy_in = $signed({{4{ay_q[15]}}, ay_q, 16'd0});
    end
  end

  tcf_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i, .rst_ni, .start_i(load_go || cy_start),
    .x_i(cx_in), .y_i(cy_in), .angle_o(cord_angle), .done_o(cord_done)
  );

  // progress flags for the RUN phase
  logic                 cxd_q, cys_q, cyd_q, sqd_q;
  logic signed [ZW-1:0] accx_q, accy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cxd_q <= 1'b0;
      cys_q <= 1'b0;
      cyd_q <= 1'b0;
      sqd_q <= 1'b0;
      dvd_q <= '0;
    end else if (load_go) begin
      cxd_q <= 1'b0;
      cys_q <= 1'b0;
      cyd_q <= 1'b0;
      sqd_q <= 1'b0;
      dvd_q <= '0;
    end else begin
      dvd_q <= dvd_q | dv_done;
      if (sq_last) sqd_q <= 1'b1;
      if (cy_start) cys_q <= 1'b1;
      if (cord_done && !cys_q) cxd_q <= 1'b1;
      if (cord_done && cys_q) cyd_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cord_done && !cys_q) accx_q <= cord_angle;
    if (cord_done && cys_q) accy_q <= cord_angle;
  end

  assign all_done = cyd_q && (&dvd_q);

  // filter state, shown directly on the result ports
  logic signed [31:0] angx_q, angy_q;
  logic signed [16:0] ratex_q, ratey_q;
  logic signed [15:0] lax_q, lay_q, laz_q;
  logic               svalid_q, out_valid_q;

  // blend: P = alpha*(old + step - acc) + acc*65536, alpha bits taken serially
  logic signed [34:0] stepx_s, stepy_s, diffx_d, diffy_d;
  logic signed [53:0] px_q, py_q, dshx_q, dshy_q;
  logic [3:0]         bl_cnt_q;

  assign stepx_s = gx_q[15] ? -$signed({9'd0, qsx[25:0]}) : $signed({9'd0, qsx[25:0]});
  assign stepy_s = gy_q[15] ? -$signed({9'd0, qsy[25:0]}) : $signed({9'd0, qsy[25:0]});
  assign diffx_d = $signed({{3{angx_q[31]}}, angx_q}) + stepx_s
                 - $signed({{8{accx_q[ZW-1]}}, accx_q});
  assign diffy_d = $signed({{3{angy_q[31]}}, angy_q}) + stepy_s
                 - $signed({{8{accy_q[ZW-1]}}, accy_q});

  // round to nearest, ties away from zero: |P| + 2^15, then drop 16 bits
  logic [53:0] pxr, pyr;
  logic [37:0] rmx_q, rmy_q;
  logic        negx_q, negy_q;

  assign pxr = (px_q[53] ? ~px_q : px_q) + (px_q[53] ? 54'd32769 : 54'd32768);
  assign pyr = (py_q[53] ? ~py_q : py_q) + (py_q[53] ? 54'd32769 : 54'd32768);

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_DIFF: begin
        px_q     <= $signed({{11{accx_q[ZW-1]}}, accx_q, 16'd0});
        py_q     <= $signed({{11{accy_q[ZW-1]}}, accy_q, 16'd0});
        dshx_q   <= $signed({{19{diffx_d[34]}}, diffx_d});
        dshy_q   <= $signed({{19{diffy_d[34]}}, diffy_d});
        bl_cnt_q <= '0;
      end
      ST_BLEND: begin
        if (alpha_q[bl_cnt_q]) begin
          px_q <= px_q + dshx_q;
          py_q <= py_q + dshy_q;
        end
        dshx_q   <= dshx_q <<< 1;
        dshy_q   <= dshy_q <<< 1;
        bl_cnt_q <= bl_cnt_q + 1'b1;
      end
      ST_ROUND: begin
        negx_q <= px_q[53];
        negy_q <= py_q[53];
        rmx_q  <= pxr[53:16];
        rmy_q  <= pyr[53:16];
      end
      default: ;
    endcase
  end

  // clamp a rounded sign/magnitude to the 32-bit signed range
  function automatic logic signed [31:0] sat32(input logic neg, input logic [37:0] m);
    logic [37:0] nm;
    begin
      nm = 38'd0 - m;
      if (neg) begin
        sat32 = (m > 38'd2147483648) ? 32'sh80000000 : $signed(nm[31:0]);
      end else begin
        sat32 = (m > 38'd2147483647) ? 32'sh7FFFFFFF : $signed(m[31:0]);
      end
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angx_q      <= '0;
      angy_q      <= '0;
      ratex_q     <= '0;
      ratey_q     <= '0;
      lax_q       <= '0;
      lay_q       <= '0;
      laz_q       <= '0;
      svalid_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
        svalid_q    <= ok_q;
        if (ok_q) begin
          angx_q  <= sat32(negx_q, rmx_q);
          angy_q  <= sat32(negy_q, rmy_q);
          ratex_q <= gx_q[15] ? 17'(17'd0 - qrx[16:0]) : $signed(qrx[16:0]);
          ratey_q <= gy_q[15] ? 17'(17'd0 - qry[16:0]) : $signed(qry[16:0]);
          lax_q   <= ax_q;
          lay_q   <= ay_q;
          laz_q   <= az_q;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (accept) state_d = in_ok ? ST_PREP : ST_FIN;
      ST_PREP:  state_d = ST_LOAD;
      ST_LOAD:  state_d = ST_RUN;
      ST_RUN:   if (all_done) state_d = ST_DIFF;
      ST_DIFF:  state_d = ST_BLEND;
      ST_BLEND: if (bl_cnt_q == 4'd15) state_d = ST_ROUND;
      ST_ROUND: state_d = ST_FIN;
      ST_FIN:   if (fin_go) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = state_q == ST_IDLE;
    load_go    = state_q == ST_LOAD;
    cy_start   = (state_q == ST_RUN) && cxd_q && sqd_q && !cys_q;
    fin_go     = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tilt_x_o       = angx_q;
  assign tilt_y_o       = angy_q;
  assign rate_x_o       = ratex_q;
  assign rate_y_o       = ratey_q;
  assign accel_x_g_o    = lax_q;
  assign accel_y_g_o    = lay_q;
  assign accel_z_g_o    = laz_q;
  assign sample_valid_o = svalid_q;

`ifndef SYNTH
  // blending starts only after every serial unit has reported
  a_blend_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIFF) |-> (cyd_q && sqd_q && cxd_q && (&dvd_q)))
    else $error("blend started before units finished");

  // a result appears only out of the finish state
  a_out_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FIN))
    else $error("result raised outside finish state");

  // no square root left running while waiting for an item
  a_idle_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sq_busy_q)
    else $error("isqrt busy in idle");
`endif

endmodule
`default_nettype wire

>>> dv/tcf_checker.sv
// Checker for the tilt filter: watches both channels, predicts each result and compares.
`timescale 1ns / 100ps
module tcf_checker import tcf_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic        [15:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [15:0] accel_x_i,
  input  logic signed [15:0] accel_y_i,
  input  logic signed [15:0] accel_z_i,
  input  logic signed [15:0] gyro_x_i,
  input  logic signed [15:0] gyro_y_i,
  input  logic        [19:0] step_time_us_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] tilt_x_i,
  input  logic signed [31:0] tilt_y_i,
  input  logic signed [16:0] rate_x_i,
  input  logic signed [16:0] rate_y_i,
  input  logic signed [15:0] accel_x_g_i,
  input  logic signed [15:0] accel_y_g_i,
  input  logic signed [15:0] accel_z_g_i,
  input  logic               sample_valid_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 rejected_o,
  output int                 clamped_o
);

  typedef struct packed {
    logic signed [31:0] tilt_x;
    logic signed [31:0] tilt_y;
    logic signed [16:0] rate_x;
    logic signed [16:0] rate_y;
    logic signed [15:0] ax;
    logic signed [15:0] ay;
    logic signed [15:0] az;
    logic               sample_valid;
  } tilt_rec_t;

  localparam longint HALF_TURN = 64'sd11796480;
  localparam longint ArcTab[32] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0};

  tilt_rec_t expected_q[$];
  tilt_rec_t held;        // angles and last record kept by the filter
  logic       link_ok;
  logic [15:0] alpha;

  assign pending_o = expected_q.size();

  function automatic longint rdiv(longint n, longint d);
    if (n >= 0) return (n + d / 2) / d;
    return -((-n + d / 2) / d);
  endfunction

  function automatic longint int_sqrt(longint unsigned n);
    longint unsigned res, bit_w;
    res = 0;
    bit_w = 64'd1 << 48;
    while (bit_w > n) bit_w >>= 2;
    while (bit_w != 0) begin
      if (n >= res + bit_w) begin
        n -= res + bit_w;
        res = (res >> 1) + bit_w;
      end else begin
        res >>= 1;
      end
      bit_w >>= 2;
    end
    return longint'(res);
  endfunction

  // vectoring CORDIC, result in 1/65536 degree
  function automatic longint vec_angle(longint y, longint x);
    longint z, xs, ys;
    int n;
    z = 0;
    n = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      z = (y >= 0) ? HALF_TURN : -HALF_TURN;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < n; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x += ys; y -= xs; z += ArcTab[i];
      end else begin
        x -= ys; y += xs; z -= ArcTab[i];
      end
    end
    return z;
  endfunction

  function automatic longint fuse_angle(longint prev, longint g, longint dt, longint acc,
                                        longint a, output logic hit);
    longint stp, v;
    stp = rdiv(g * dt * 65536, 131000000);
    v = rdiv(a * (prev + stp) + (65536 - a) * acc, 65536);
    hit = 1'b0;
    if (v > 64'sd2147483647) begin v = 64'sd2147483647; hit = 1'b1; end
    if (v < -64'sd2147483648) begin v = -64'sd2147483648; hit = 1'b1; end
    return v;
  endfunction

  task automatic report(input string what, input longint got, input longint want);
    $display("[%0t] mismatch %s: got %0d, expected %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint ax, ay, az, mag, accx, accy;
    logic hx, hy;
    tilt_rec_t w;
    if (!rst_ni) begin
      link_ok = 1'b0;
      alpha = ALPHA_RST;
      held = '0;
      expected_q.delete();
      errors_o = 0; checked_o = 0; rejected_o = 0; clamped_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_SENSOR_OK) link_ok = cfg_wdata_i[0];
        else alpha = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) begin
        if (link_ok && step_time_us_i != 0) begin
          ax = accel_x_i; ay = accel_y_i; az = accel_z_i;
          mag = int_sqrt(longint'(ay * ay + az * az) << 16);
          accx = vec_angle(ay * 65536, az * 65536);
          accy = vec_angle(-ax * 65536, mag * 256);
          held.tilt_x = fuse_angle(held.tilt_x, gyro_x_i, step_time_us_i, accx, alpha, hx);
          held.tilt_y = fuse_angle(held.tilt_y, gyro_y_i, step_time_us_i, accy, alpha, hy);
          if (hx || hy) clamped_o++;
          held.rate_x = rdiv(longint'(gyro_x_i) * 256, 131);
          held.rate_y = rdiv(longint'(gyro_y_i) * 256, 131);
          held.ax = accel_x_i; held.ay = accel_y_i; held.az = accel_z_i;
          w = held;
          w.sample_valid = 1'b1;
        end else begin
          w = held;
          w.sample_valid = 1'b0;
          rejected_o++;
        end
        expected_q.push_back(w);
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          w = expected_q.pop_front();
          checked_o++;
          if (tilt_x_i != w.tilt_x) report("tilt_x", tilt_x_i, w.tilt_x);
          if (tilt_y_i != w.tilt_y) report("tilt_y", tilt_y_i, w.tilt_y);
          if (rate_x_i != w.rate_x) report("rate_x", rate_x_i, w.rate_x);
          if (rate_y_i != w.rate_y) report("rate_y", rate_y_i, w.rate_y);
          if (accel_x_g_i != w.ax) report("accel_x_g", accel_x_g_i, w.ax);
          if (accel_y_g_i != w.ay) report("accel_y_g", accel_y_g_i, w.ay);
          if (accel_z_g_i != w.az) report("accel_z_g", accel_z_g_i, w.az);
          if (sample_valid_i != w.sample_valid)
            report("sample_valid", sample_valid_i, w.sample_valid);
        end
      end
    end
  end

endmodule

>>> dv/testbench.sv
// Testbench top: drives samples and register writes into the tilt filter and gives the verdict.
`timescale 1ns / 100ps
module testbench;
  import tcf_pkg::*;

  localparam int IdleLimit = 3000;   // cycles with no item moving on either channel

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = CFG_SENSOR_OK;
  logic [15:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [15:0] accel_x_i = '0, accel_y_i = '0, accel_z_i = '0;
  logic signed [15:0] gyro_x_i = '0, gyro_y_i = '0;
  logic [19:0] step_time_us_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] tilt_x_o, tilt_y_o;
  logic signed [16:0] rate_x_o, rate_y_o;
  logic signed [15:0] accel_x_g_o, accel_y_g_o, accel_z_g_o;
  logic sample_valid_o;

  int errors, pending, checked, rejected, clamped;
  int idle_cycles;
  logic ready_seen;       // in_ready_o as it stands before the next rising edge
  int burst_left;
  int sent;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  tilt_complementary_filter i_dut (.*);

  tcf_checker i_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o),
    .accel_x_i, .accel_y_i, .accel_z_i, .gyro_x_i, .gyro_y_i, .step_time_us_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .tilt_x_i(tilt_x_o), .tilt_y_i(tilt_y_o), .rate_x_i(rate_x_o), .rate_y_i(rate_y_o),
    .accel_x_g_i(accel_x_g_o), .accel_y_g_i(accel_y_g_o), .accel_z_g_i(accel_z_g_o),
    .sample_valid_i(sample_valid_o),
    .errors_o(errors), .pending_o(pending), .checked_o(checked),
    .rejected_o(rejected), .clamped_o(clamped)
  );

  always @(negedge clk_i) ready_seen <= in_ready_o;

  // Receiver stalls in windows of random length, each with its own stall odds (0 = no stall).
  always @(posedge clk_i) begin
    int unsigned stall_pct;
    if ($urandom_range(0, 63) == 0) stall_pct = $urandom_range(0, 3) * 25;
    out_ready_i <= ($urandom_range(1, 100) > stall_pct);
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no item moved for %0d cycles", IdleLimit);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // One sample; holds valid until accepted, then maybe opens a gap (burst end).
  task automatic send(input logic signed [15:0] ax, input logic signed [15:0] ay,
                      input logic signed [15:0] az, input logic signed [15:0] gx,
                      input logic signed [15:0] gy, input logic [19:0] dt);
    int gap;
    in_valid_i <= 1'b1;
    accel_x_i <= ax; accel_y_i <= ay; accel_z_i <= az;
    gyro_x_i <= gx; gyro_y_i <= gy; step_time_us_i <= dt;
    do @(posedge clk_i); while (!ready_seen);
    sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  // Let every expected result drain, plus the short rejected-item latency.
  task automatic drain;
    in_valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  function automatic logic signed [15:0] rnd16;
    return 16'($urandom());
  endfunction

  // Random sample; mode picks the flavor of the content.
  task automatic send_random(input int mode);
    logic [19:0] dt;
    int unsigned r;
    r = $urandom_range(0, 99);
    dt = (r < 5) ? 20'd0 : (r < 60) ? 20'($urandom_range(500, 20000)) : 20'($urandom());
    case (mode)
      1: send(rnd16(), rnd16(), rnd16(), 16'sd32767 - 16'($urandom_range(0, 50)),
              -16'sd32768 + 16'($urandom_range(0, 50)), 20'hFFFFF - 20'($urandom_range(0, 9)));
      2: send(-16'sd32768 + 16'($urandom_range(0, 50)), rnd16(), rnd16(),
              -16'sd32768, 16'sd32767, 20'hFFFFF);
      default: begin
        if (r % 3 == 0)  // tilt-like content near 1 g
          send(16'($signed($urandom_range(0, 8000)) - 4000),
               16'($signed($urandom_range(0, 8000)) - 4000),
               16'($signed($urandom_range(0, 36000)) - 18000),
               16'($signed($urandom_range(0, 2000)) - 1000),
               16'($signed($urandom_range(0, 2000)) - 1000), dt);
        else
          send(rnd16(), rnd16(), rnd16(), rnd16(), rnd16(), dt);
      end
    endcase
  endtask

  initial begin
    sent = 0;
    burst_left = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Sensor not confirmed yet: everything is rejected with a zero record.
    send(16'sd1000, 16'sd2000, 16'sd3000, 16'sd131, -16'sd131, 20'd1000);
    send(-16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 20'hFFFFF);
    drain();

    write_reg(CFG_SENSOR_OK, 16'd1);
    // Field extremes, axis-aligned vectors, left half plane, zero vector, zero dt.
    send(16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'sd0, 20'd1000);
    send(16'sd0, 16'sd0, 16'sd0, 16'sd131, 16'sd262, 20'd1000);            // zero y-z vector
    send(16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 20'd1000);           // left, y = 0
    send(16'sd100, -16'sd5, -16'sd16384, 16'sd0, 16'sd0, 20'd1000);        // left, y < 0
    send(16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 20'd1);
    send(-16'sd16384, -16'sd16384, 16'sd0, 16'sd0, 16'sd0, 20'd1);
    send(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 20'hFFFFF);
    send(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 20'hFFFFF);
    send(16'sd1, -16'sd1, 16'sd1, 16'sd65, -16'sd65, 20'd1);               // rate rounding, both signs
    send(16'sd500, 16'sd500, 16'sd500, 16'sd1234, 16'sd4321, 20'd0);       // zero dt rejects
    send(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 20'd0);
    send(-16'sd1, 16'sd0, -16'sd1, -16'sd1, 16'sd1, 20'h80000);
    drain();

    write_reg(CFG_ALPHA, 16'd0);           // accel angles only
    for (int i = 0; i < 150; i++) send_random(0);
    drain();
    write_reg(CFG_ALPHA, 16'd65535);       // nearly pure gyro: drive into both clamps
    for (int i = 0; i < 170; i++) send_random(1);
    for (int i = 0; i < 170; i++) send_random(2);
    drain();
    write_reg(CFG_ALPHA, ALPHA_RST);
    for (int i = 0; i < 300; i++) send_random(0);
    drain();
    write_reg(CFG_SENSOR_OK, 16'd0);
    for (int i = 0; i < 40; i++) send_random(0);
    drain();
    write_reg(CFG_SENSOR_OK, 16'hFFFF);    // only bit 0 counts
    write_reg(CFG_ALPHA, 16'($urandom()));
    for (int i = 0; i < 200; i++) send_random(0);
    drain();
    write_reg(CFG_ALPHA, 16'd32768);
    for (int i = 0; i < 150; i++) send_random(0);
    drain();
    repeat (100) @(posedge clk_i);

    $display("Run sent %0d samples; %0d results checked, %0d of them rejected samples,",
             sent, checked, rejected);
    $display("and %0d accepted samples hit the angle clamp.", clamped);
    if (errors == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results still outstanding", errors, pending);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
